// ----- src/fbcd_pkg.sv -----
// ============================================================================
// fbcd_pkg: shared types and constants for the block cache directory
// Operation codes, register indexes, field widths and controller/datapath
// command and status bundles.
// ============================================================================
package fbcd_pkg;

    // field widths fixed by the interface
    localparam int ID_W       = 16;
    localparam int NODE_W     = 6;
    localparam int NC_W       = 7;
    localparam int CE_W       = 5;
    localparam int SLOT_W     = 4;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    // parameter defaults
    localparam int DEF_CACHE_DEPTH = 16;
    localparam int DEF_ID_BITS     = 16;

    localparam logic [NC_W-1:0] MAX_NODES = 7'd64;

    // operation codes
    localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FILL   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_INVAL  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_NONE   = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT    = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT   = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_NODE      = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CACHE_ENTRIES = 4'd3;

    typedef struct packed {
        logic load;        // capture the input word
        logic per_start;   // start blocks-per-node division
        logic per_store;   // keep blocks-per-node quotient
        logic own_start;   // start owner division
        logic scan_start;  // start tag search (lookup, invalidate)
        logic commit;      // update directory, load result register
    } t_cmd;

    typedef struct packed {
        logic per_ok;      // blocks-per-node is current
        logic div_busy;
        logic scan_busy;
    } t_sts;

endpackage

// ----- src/fbcd_div.sv -----
// ============================================================================
// fbcd_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle.
// ============================================================================
module fbcd_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [fbcd_pkg::ID_W-1:0] i_dividend,
    input  logic [fbcd_pkg::ID_W-1:0] i_divisor,
    output logic                      o_busy,
    output logic [fbcd_pkg::ID_W-1:0] o_quotient,
    output logic [fbcd_pkg::ID_W-1:0] o_remainder
);

    localparam int W   = fbcd_pkg::ID_W;
    localparam int C_W = $clog2(W + 1);

    logic [C_W-1:0] r_cnt;
    logic [W-1:0]   r_rem;
    logic [W-1:0]   r_q;
    logic [W-1:0]   r_dvs;

    logic [W:0] trial;
    logic [W:0] diff;
    logic       ge;

    assign trial = {r_rem, r_q[W-1]};
    assign diff  = trial - {1'b0, r_dvs};
    assign ge    = (trial >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= C_W'(W);
            r_rem <= '0;
            r_q   <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - C_W'(1);
            r_rem <= ge ? diff[W-1:0] : trial[W-1:0];
            r_q   <= {r_q[W-2:0], ge};
        end
    end

    assign o_busy      = (r_cnt != '0);
    assign o_quotient  = r_q;
    assign o_remainder = r_rem;

endmodule

// ----- src/fbcd_datapath.sv -----
// ============================================================================
// fbcd_datapath: configuration, home-node arithmetic and tag directory
// Holds the registers, the shared divider, the tag memory with its valid
// bits, the search sequencer and the result register.
// ============================================================================
module fbcd_datapath #(
    parameter int CACHE_DEPTH = fbcd_pkg::DEF_CACHE_DEPTH,
    parameter int ID_BITS     = fbcd_pkg::DEF_ID_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  fbcd_pkg::t_cmd                  i_cmd,
    output fbcd_pkg::t_sts                  o_sts,
    input  logic [fbcd_pkg::MODE_W-1:0]     i_mode,
    input  logic [fbcd_pkg::ID_W-1:0]       i_block_id,
    input  logic                            i_cfg_we,
    input  logic [fbcd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [fbcd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic [fbcd_pkg::NODE_W-1:0]     o_owner_node,
    output logic                            o_out_of_range,
    output logic                            o_is_local,
    output logic                            o_hit,
    output logic [fbcd_pkg::SLOT_W-1:0]     o_slot,
    output logic                            o_evicted_valid,
    output logic [fbcd_pkg::ID_W-1:0]       o_evicted_id
);

    localparam int IDX_W = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;
    localparam int CNT_W = $clog2(CACHE_DEPTH + 1);
    localparam int EW    = (CNT_W > fbcd_pkg::CE_W) ? CNT_W : fbcd_pkg::CE_W;
    localparam int TAG_W = (ID_BITS < fbcd_pkg::ID_W) ? ID_BITS : fbcd_pkg::ID_W;
    localparam int IW    = fbcd_pkg::ID_W;
    localparam int NW    = fbcd_pkg::NODE_W;
    localparam int NCW   = fbcd_pkg::NC_W;
    localparam int SW    = fbcd_pkg::SLOT_W;

    // configuration
    logic [NCW-1:0]              r_node_count;
    logic [IW-1:0]               r_block_count;
    logic [NW-1:0]               r_own_node;
    logic [fbcd_pkg::CE_W-1:0]   r_cache_entries;
    logic [IW-1:0]               r_per;
    logic                        r_per_ok;

    // current word
    logic [fbcd_pkg::MODE_W-1:0] r_mode;
    logic [IW-1:0]               r_id;

    // directory
    logic [TAG_W-1:0]            r_tag_mem [CACHE_DEPTH];
    logic [CACHE_DEPTH-1:0]      r_valid;
    logic [CACHE_DEPTH-1:0]      r_written;
    logic [IDX_W-1:0]            r_ptr;
    logic [TAG_W-1:0]            r_rd_tag;
    logic                        r_rd_valid;
    logic                        r_rd_written;

    // search
    logic                        r_scan_on;
    logic                        r_pend;
    logic [CNT_W-1:0]            r_scan_i;
    logic [IDX_W-1:0]            r_pend_idx;
    logic                        r_found;
    logic [IDX_W-1:0]            r_hit_idx;

    // result
    logic [NW-1:0]               r_owner;
    logic                        r_oor;
    logic                        r_local;
    logic                        r_hit;
    logic [SW-1:0]               r_slot;
    logic                        r_ev_valid;
    logic [IW-1:0]               r_ev_id;

    logic [NCW-1:0]   nodes;
    logic [EW-1:0]    ce_ext;
    logic [CNT_W-1:0] entries;
    logic [IDX_W-1:0] fill_slot;
    logic [IDX_W-1:0] next_ptr;
    logic [IW-1:0]    id_masked;
    logic [IDX_W-1:0] rd_addr;
    logic             mem_re;
    logic             match_now;
    logic             scan_issue;
    logic             div_start;
    logic [IW-1:0]    div_dividend;
    logic [IW-1:0]    div_divisor;
    logic             div_busy;
    logic [IW-1:0]    div_q;
    logic [IW-1:0]    div_r;
    logic [NW-1:0]    owner;
    logic             oor;

    // clamp node count and entry count into their working ranges
    always_comb begin
        if (r_node_count == '0) begin
            nodes = NCW'(1);
        end else if (r_node_count > fbcd_pkg::MAX_NODES) begin
            nodes = fbcd_pkg::MAX_NODES;
        end else begin
            nodes = r_node_count;
        end
    end

    assign ce_ext = EW'(r_cache_entries);

    always_comb begin
        if (ce_ext == '0) begin
            entries = CNT_W'(1);
        end else if (ce_ext > EW'(CACHE_DEPTH)) begin
            entries = CNT_W'(CACHE_DEPTH);
        end else begin
            entries = CNT_W'(ce_ext);
        end
    end

    // fall back to slot 0 when the pointer lies beyond the entries in use
    assign fill_slot = (CNT_W'(r_ptr) < entries) ? r_ptr : '0;
    assign next_ptr  = ((CNT_W'(fill_slot) + CNT_W'(1)) == entries) ? '0 :
                       IDX_W'(CNT_W'(fill_slot) + CNT_W'(1));

    assign id_masked = IW'(i_block_id[TAG_W-1:0]);

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count    <= NCW'(1);
            r_block_count   <= IW'(1);
            r_own_node      <= '0;
            r_cache_entries <= fbcd_pkg::CE_W'(1);
            r_per_ok        <= 1'b0;
        end else begin
            if (i_cmd.per_store) begin
                r_per_ok <= 1'b1;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    fbcd_pkg::CFG_NODE_COUNT: begin
                        r_node_count <= i_cfg_data[NCW-1:0];
                        r_per_ok     <= 1'b0;
                    end
                    fbcd_pkg::CFG_BLOCK_COUNT: begin
                        r_block_count <= i_cfg_data[IW-1:0];
                        r_per_ok      <= 1'b0;
                    end
                    fbcd_pkg::CFG_OWN_NODE: begin
                        r_own_node <= i_cfg_data[NW-1:0];
                    end
                    fbcd_pkg::CFG_CACHE_ENTRIES: begin
                        r_cache_entries <= i_cfg_data[fbcd_pkg::CE_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.per_store) begin
            r_per <= div_q;
        end
        if (i_cmd.load) begin
            r_mode <= i_mode;
            r_id   <= id_masked;
        end
    end

    // shared divider: blocks per node, then the owner
    assign div_start    = i_cmd.per_start || i_cmd.own_start;
    assign div_dividend = i_cmd.per_start ? r_block_count : r_id;
    assign div_divisor  = (i_cmd.per_start || (r_per == '0)) ? IW'(nodes) : r_per;

    fbcd_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (div_dividend),
        .i_divisor   (div_divisor),
        .o_busy      (div_busy),
        .o_quotient  (div_q),
        .o_remainder (div_r)
    );

    always_comb begin
        if (r_per == '0) begin
            owner = div_r[NW-1:0];
        end else if (div_q >= IW'(nodes)) begin
            owner = NW'(nodes - NCW'(1));
        end else begin
            owner = div_q[NW-1:0];
        end
    end

    assign oor = (r_id >= r_block_count);

    // search: one read per cycle, compare on the registered tag
    assign match_now  = r_scan_on && r_pend && r_rd_valid &&
                        (r_rd_tag == r_id[TAG_W-1:0]);
    assign scan_issue = r_scan_on && !match_now && (r_scan_i < entries);
    assign rd_addr    = i_cmd.load ? fill_slot : r_scan_i[IDX_W-1:0];
    assign mem_re     = (i_cmd.load && (i_mode == fbcd_pkg::MODE_FILL)) || scan_issue;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_on <= 1'b0;
            r_pend    <= 1'b0;
            r_found   <= 1'b0;
        end else if (i_cmd.load) begin
            r_found <= 1'b0;
        end else if (i_cmd.scan_start &&
                     ((r_mode == fbcd_pkg::MODE_LOOKUP) ||
                      (r_mode == fbcd_pkg::MODE_INVAL))) begin
            r_scan_on <= 1'b1;
            r_pend    <= 1'b0;
            r_scan_i  <= '0;
        end else if (r_scan_on) begin
            if (match_now) begin
                r_found   <= 1'b1;
                r_hit_idx <= r_pend_idx;
                r_scan_on <= 1'b0;
                r_pend    <= 1'b0;
            end else if (scan_issue) begin
                r_pend     <= 1'b1;
                r_pend_idx <= r_scan_i[IDX_W-1:0];
                r_scan_i   <= r_scan_i + CNT_W'(1);
            end else begin
                r_scan_on <= 1'b0;
                r_pend    <= 1'b0;
            end
        end
    end

    // tag memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && (r_mode == fbcd_pkg::MODE_FILL)) begin
            r_tag_mem[fill_slot] <= r_id[TAG_W-1:0];
        end
        if (mem_re) begin
            r_rd_tag <= r_tag_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_rd_valid   <= r_valid[rd_addr];
            r_rd_written <= r_written[rd_addr];
        end
    end

    // valid bits, fill marks and replacement pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_written <= '0;
            r_ptr     <= '0;
        end else if (i_cmd.commit) begin
            if (r_mode == fbcd_pkg::MODE_FILL) begin
                r_valid[fill_slot]   <= 1'b1;
                r_written[fill_slot] <= 1'b1;
                r_ptr                <= next_ptr;
            end else if ((r_mode == fbcd_pkg::MODE_INVAL) && r_found) begin
                r_valid[r_hit_idx] <= 1'b0;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_owner    <= '0;
            r_oor      <= 1'b0;
            r_local    <= 1'b0;
            r_hit      <= 1'b0;
            r_slot     <= '0;
            r_ev_valid <= 1'b0;
            r_ev_id    <= '0;
            if (r_mode != fbcd_pkg::MODE_NONE) begin
                r_oor   <= oor;
                r_owner <= oor ? '0 : owner;
            end
            case (r_mode)
                fbcd_pkg::MODE_LOOKUP: begin
                    if (!oor) begin
                        if (owner == r_own_node) begin
                            r_local <= 1'b1;
                        end else if (r_found) begin
                            r_hit  <= 1'b1;
                            r_slot <= SW'(r_hit_idx);
                        end
                    end
                end
                fbcd_pkg::MODE_FILL: begin
                    r_slot     <= SW'(fill_slot);
                    r_ev_valid <= r_rd_valid;
                    // an entry never filled is reported with the all-ones tag
                    r_ev_id    <= r_rd_written ? IW'(r_rd_tag) : IW'({TAG_W{1'b1}});
                end
                fbcd_pkg::MODE_INVAL: begin
                    if (r_found) begin
                        r_hit  <= 1'b1;
                        r_slot <= SW'(r_hit_idx);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_sts.per_ok    = r_per_ok;
    assign o_sts.div_busy  = div_busy;
    assign o_sts.scan_busy = r_scan_on;

    assign o_owner_node    = r_owner;
    assign o_out_of_range  = r_oor;
    assign o_is_local      = r_local;
    assign o_hit           = r_hit;
    assign o_slot          = r_slot;
    assign o_evicted_valid = r_ev_valid;
    assign o_evicted_id    = r_ev_id;

endmodule

// ----- src/fbcd_ctrl.sv -----
// ============================================================================
// fbcd_ctrl: sequencer for the block cache directory
// Steps each word through the divisions and the search that it needs, then commits it
// to the result register when that register is free.
// ============================================================================
module fbcd_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic [fbcd_pkg::MODE_W-1:0] i_mode,
    output logic                        o_in_ready,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output fbcd_pkg::t_cmd              o_cmd,
    input  fbcd_pkg::t_sts              i_sts
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PER  = 3'd1;
    localparam logic [2:0] S_PERW = 3'd2;
    localparam logic [2:0] S_OWN  = 3'd3;
    localparam logic [2:0] S_OWNW = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       out_free;

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_mode == fbcd_pkg::MODE_NONE) begin
                        n_state = S_DONE;
                    end else if (i_sts.per_ok) begin
                        n_state = S_OWN;
                    end else begin
                        n_state = S_PER;
                    end
                end
            end
            S_PER: begin
                o_cmd.per_start = 1'b1;
                n_state         = S_PERW;
            end
            S_PERW: begin
                if (!i_sts.div_busy) begin
                    o_cmd.per_store = 1'b1;
                    n_state         = S_OWN;
                end
            end
            S_OWN: begin
                o_cmd.own_start  = 1'b1;
                o_cmd.scan_start = 1'b1;
                n_state          = S_OWNW;
            end
            S_OWNW: begin
                if (!i_sts.div_busy && !i_sts.scan_busy) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // hold until the previous result is taken
                if (out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    a_commit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |-> (!r_out_valid || i_out_ready))
        else $error("result committed over an untaken result");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state != S_IDLE))
        else $error("accepted word did not start processing");

    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (!i_sts.div_busy && !i_sts.scan_busy))
        else $error("divider or search still running while idle");

    a_div_start_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.per_start || o_cmd.own_start) |-> !i_sts.div_busy)
        else $error("divider restarted while busy");

endmodule

// ----- src/fifo_block_cache_directory.sv -----
// ============================================================================
// fifo_block_cache_directory: block cache directory with home-node lookup
// Fully associative directory with FIFO replacement; each word is a lookup,
// fill, invalidate or unused-mode word, and gives one result word.
// ============================================================================
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+----------------------------
//  in       | sink      | i_in_valid/o_in_ready   | i_mode, i_block_id
//  out      | source    | o_out_valid/i_out_ready | o_owner_node .. o_evicted_id
//  cfg      | sink      | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
//
//  A word passes through accept, divider start, the divider steps, wait exit
//  and commit; the iterative divider for the owner sets its length. A lookup
//  or invalidate whose search reaches the sixteenth entry can outlast the
//  divider, as the search runs beside the owner division. A word of the
//  unused mode goes from accept straight to commit.
//  After a write to node_count or block_count the next word first recomputes
//  blocks per node on the same divider.
//  Reset clears the valid bits at once; no clearing pass.
//  A result waits in the output register; the next word is accepted and
//  held before commit until that result is taken.
module fifo_block_cache_directory #(
    parameter int CACHE_DEPTH = fbcd_pkg::DEF_CACHE_DEPTH,
    parameter int ID_BITS     = fbcd_pkg::DEF_ID_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [fbcd_pkg::MODE_W-1:0]     i_mode,
    input  logic [fbcd_pkg::ID_W-1:0]       i_block_id,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [fbcd_pkg::NODE_W-1:0]     o_owner_node,
    output logic                            o_out_of_range,
    output logic                            o_is_local,
    output logic                            o_hit,
    output logic [fbcd_pkg::SLOT_W-1:0]     o_slot,
    output logic                            o_evicted_valid,
    output logic [fbcd_pkg::ID_W-1:0]       o_evicted_id,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [fbcd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [fbcd_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    fbcd_pkg::t_cmd cmd;
    fbcd_pkg::t_sts sts;

    assign o_cfg_ready = 1'b1;

    fbcd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_mode      (i_mode),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    fbcd_datapath #(
        .CACHE_DEPTH (CACHE_DEPTH),
        .ID_BITS     (ID_BITS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_mode          (i_mode),
        .i_block_id      (i_block_id),
        .i_cfg_we        (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_owner_node    (o_owner_node),
        .o_out_of_range  (o_out_of_range),
        .o_is_local      (o_is_local),
        .o_hit           (o_hit),
        .o_slot          (o_slot),
        .o_evicted_valid (o_evicted_valid),
        .o_evicted_id    (o_evicted_id)
    );

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps
// ============================================================================
// tb: self-checking bench for the FIFO block cache directory
// Drives lookup, fill, invalidate and unused-mode words through the valid/ready
// input, predicts owner node, hit/slot and eviction for each word with a local
// copy of the directory, and compares every result word field by field. Register
// settings are changed between phases while the block is idle.
// ============================================================================
module tb;

    localparam int UNUSED_IDX_LO = 4;
    localparam int UNUSED_IDX_HI = 15;
    localparam int RX_LONG_HOLD  = 300;
    localparam int DRAIN_CYCLES  = 60;

    typedef struct packed {
        logic [fbcd_pkg::NODE_W-1:0] owner_node;
        logic                        out_of_range;
        logic                        is_local;
        logic                        hit;
        logic [fbcd_pkg::SLOT_W-1:0] slot;
        logic                        evicted_valid;
        logic [fbcd_pkg::ID_W-1:0]   evicted_id;
    } t_dir_result;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_in_valid = 1'b0;
    logic                            o_in_ready;
    logic [fbcd_pkg::MODE_W-1:0]     i_mode = fbcd_pkg::MODE_LOOKUP;
    logic [fbcd_pkg::ID_W-1:0]       i_block_id = '0;
    logic                            o_out_valid;
    logic                            i_out_ready = 1'b0;
    logic [fbcd_pkg::NODE_W-1:0]     o_owner_node;
    logic                            o_out_of_range;
    logic                            o_is_local;
    logic                            o_hit;
    logic [fbcd_pkg::SLOT_W-1:0]     o_slot;
    logic                            o_evicted_valid;
    logic [fbcd_pkg::ID_W-1:0]       o_evicted_id;
    logic                            i_cfg_valid = 1'b0;
    logic                            o_cfg_ready;
    logic [fbcd_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [fbcd_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    fifo_block_cache_directory dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_mode          (i_mode),
        .i_block_id      (i_block_id),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_owner_node    (o_owner_node),
        .o_out_of_range  (o_out_of_range),
        .o_is_local      (o_is_local),
        .o_hit           (o_hit),
        .o_slot          (o_slot),
        .o_evicted_valid (o_evicted_valid),
        .o_evicted_id    (o_evicted_id),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // local copy of registers and directory
    logic [fbcd_pkg::NC_W-1:0]   cfg_nodes;
    logic [fbcd_pkg::ID_W-1:0]   cfg_blocks;
    logic [fbcd_pkg::NODE_W-1:0] cfg_own;
    logic [fbcd_pkg::CE_W-1:0]   cfg_entries;
    logic [fbcd_pkg::ID_W-1:0]   tag_store [fbcd_pkg::DEF_CACHE_DEPTH];
    logic                        tag_valid [fbcd_pkg::DEF_CACHE_DEPTH];
    int unsigned                 fill_ptr;

    t_dir_result pending_results[$];
    int          mismatch_count = 0;
    int          words_sent = 0;
    int          words_checked = 0;
    int          settings_count = 0;
    bit          no_idle = 1'b0;
    int          rx_hold = 0;

    function automatic int find_tag(logic [fbcd_pkg::ID_W-1:0] id, int unsigned e);
        for (int i = 0; i < e; i++)
            if (tag_valid[i] && tag_store[i] == id) return i;
        return -1;
    endfunction

    function automatic t_dir_result directory_predict(logic [fbcd_pkg::MODE_W-1:0] mode,
                                                      logic [fbcd_pkg::ID_W-1:0] id);
        t_dir_result r;
        int unsigned n, e, per, q, s;
        int          k;
        r = '0;
        n = (cfg_nodes == 0) ? 1 :
            ((cfg_nodes > fbcd_pkg::MAX_NODES) ? fbcd_pkg::MAX_NODES : cfg_nodes);
        e = (cfg_entries == 0) ? 1 :
            ((cfg_entries > fbcd_pkg::DEF_CACHE_DEPTH) ? fbcd_pkg::DEF_CACHE_DEPTH
                                                        : cfg_entries);
        if (mode != fbcd_pkg::MODE_NONE) begin
            if (id >= cfg_blocks) begin
                r.out_of_range = 1'b1;
            end else begin
                per = cfg_blocks / n;
                if (per == 0) begin
                    q = id % n;
                end else begin
                    q = id / per;
                    if (q >= n) q = n - 1;
                end
                r.owner_node = q[fbcd_pkg::NODE_W-1:0];
            end
        end
        case (mode)
            fbcd_pkg::MODE_LOOKUP: begin
                if (!r.out_of_range) begin
                    if (r.owner_node == cfg_own) begin
                        r.is_local = 1'b1;
                    end else begin
                        k = find_tag(id, e);
                        if (k >= 0) begin
                            r.hit  = 1'b1;
                            r.slot = k[fbcd_pkg::SLOT_W-1:0];
                        end
                    end
                end
            end
            fbcd_pkg::MODE_FILL: begin
                // a stale pointer past the entries in use restarts at slot 0
                s = (fill_ptr < e) ? fill_ptr : 0;
                r.evicted_valid = tag_valid[s];
                r.evicted_id    = tag_store[s];
                tag_store[s]    = id;
                tag_valid[s]    = 1'b1;
                r.slot          = s[fbcd_pkg::SLOT_W-1:0];
                fill_ptr        = (s + 1) % e;
            end
            fbcd_pkg::MODE_INVAL: begin
                k = find_tag(id, e);
                if (k >= 0) begin
                    tag_valid[k] = 1'b0;
                    r.hit        = 1'b1;
                    r.slot       = k[fbcd_pkg::SLOT_W-1:0];
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    task automatic send_word(logic [fbcd_pkg::MODE_W-1:0] mode,
                             logic [fbcd_pkg::ID_W-1:0] id);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_mode     <= mode;
        i_block_id <= id;
        do @(posedge i_clk); while (!o_in_ready);
        pending_results.push_back(directory_predict(mode, id));
        words_sent++;
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_register(logic [fbcd_pkg::CFG_IDX_W-1:0] idx,
                                  logic [fbcd_pkg::CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            fbcd_pkg::CFG_NODE_COUNT:    cfg_nodes   = data[fbcd_pkg::NC_W-1:0];
            fbcd_pkg::CFG_BLOCK_COUNT:   cfg_blocks  = data[fbcd_pkg::ID_W-1:0];
            fbcd_pkg::CFG_OWN_NODE:      cfg_own     = data[fbcd_pkg::NODE_W-1:0];
            fbcd_pkg::CFG_CACHE_ENTRIES: cfg_entries = data[fbcd_pkg::CE_W-1:0];
            default: ;
        endcase
    endtask

    // garble fills the bits above each register's width and pokes an unused index
    task automatic apply_settings(int unsigned nc, int unsigned bc, int unsigned own,
                                  int unsigned ce, bit garble);
        logic [fbcd_pkg::CFG_DATA_W-1:0] d;
        wait_idle();
        d = garble ? fbcd_pkg::CFG_DATA_W'($urandom) : '0;
        d[fbcd_pkg::NC_W-1:0] = nc[fbcd_pkg::NC_W-1:0];
        write_register(fbcd_pkg::CFG_NODE_COUNT, d);
        write_register(fbcd_pkg::CFG_BLOCK_COUNT, bc[fbcd_pkg::CFG_DATA_W-1:0]);
        d = garble ? fbcd_pkg::CFG_DATA_W'($urandom) : '0;
        d[fbcd_pkg::NODE_W-1:0] = own[fbcd_pkg::NODE_W-1:0];
        write_register(fbcd_pkg::CFG_OWN_NODE, d);
        d = garble ? fbcd_pkg::CFG_DATA_W'($urandom) : '0;
        d[fbcd_pkg::CE_W-1:0] = ce[fbcd_pkg::CE_W-1:0];
        write_register(fbcd_pkg::CFG_CACHE_ENTRIES, d);
        if (garble)
            write_register(
                fbcd_pkg::CFG_IDX_W'($urandom_range(UNUSED_IDX_LO, UNUSED_IDX_HI)),
                fbcd_pkg::CFG_DATA_W'($urandom));
        i_cfg_valid <= 1'b0;
        settings_count++;
    endtask

    // result checker: one stall draw per word, long hold when requested
    initial begin
        int stall;
        t_dir_result want;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (rx_hold > 0) begin
                stall = rx_hold;
                rx_hold = 0;
            end else begin
                stall = no_idle ? 0 : $urandom_range(0, 10);
            end
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            if (pending_results.size() == 0) begin
                $error("result word with no prediction pending");
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("owner_node", want.owner_node, o_owner_node);
                check_field("out_of_range", want.out_of_range, o_out_of_range);
                check_field("is_local", want.is_local, o_is_local);
                check_field("hit", want.hit, o_hit);
                check_field("slot", want.slot, o_slot);
                check_field("evicted_valid", want.evicted_valid, o_evicted_valid);
                check_field("evicted_id", want.evicted_id, o_evicted_id);
                words_checked++;
            end
        end
    end

    task automatic test_reset_state();
        // reset settings: one node, one block, one entry
        send_word(fbcd_pkg::MODE_LOOKUP, 16'd0);
        send_word(fbcd_pkg::MODE_LOOKUP, 16'd1);
        send_word(fbcd_pkg::MODE_FILL, 16'hFFFF);
        send_word(fbcd_pkg::MODE_FILL, 16'd0);
        send_word(fbcd_pkg::MODE_INVAL, 16'd0);
        send_word(fbcd_pkg::MODE_INVAL, 16'd0);
        send_word(fbcd_pkg::MODE_NONE, 16'hFFFF);
    endtask

    task automatic test_home_node();
        apply_settings(4, 103, 3, 16, 1'b0);
        send_word(fbcd_pkg::MODE_LOOKUP, 16'd0);
        send_word(fbcd_pkg::MODE_LOOKUP, 16'd50);
        send_word(fbcd_pkg::MODE_LOOKUP, 16'd102);   // quotient past last node, clamp
        // fewer blocks than nodes: owner is id mod nodes
        apply_settings(8, 3, 63, 16, 1'b0);
        send_word(fbcd_pkg::MODE_LOOKUP, 16'd2);
        // zero node and entry counts act as one
        apply_settings(0, 65535, 0, 0, 1'b0);
        send_word(fbcd_pkg::MODE_LOOKUP, 16'd65534);
        // node count above the maximum acts as the maximum
        apply_settings(127, 65535, 5, 31, 1'b1);
        send_word(fbcd_pkg::MODE_LOOKUP, 16'd65534);
        send_word(fbcd_pkg::MODE_LOOKUP, 16'd65535);
        send_word(fbcd_pkg::MODE_LOOKUP, 16'd5200);
    endtask

    task automatic test_fifo_replacement();
        apply_settings(2, 65535, 63, 3, 1'b0);
        send_word(fbcd_pkg::MODE_FILL, 16'h1234);
        send_word(fbcd_pkg::MODE_FILL, 16'hABCD);
        send_word(fbcd_pkg::MODE_FILL, 16'h1234);    // duplicate tag
        send_word(fbcd_pkg::MODE_FILL, 16'h0F0F);    // wraps, evicts slot 0
        send_word(fbcd_pkg::MODE_LOOKUP, 16'h1234);
        send_word(fbcd_pkg::MODE_INVAL, 16'h1234);
        send_word(fbcd_pkg::MODE_LOOKUP, 16'h1234);
        // shrink below the pointer: next fill lands in slot 0
        apply_settings(2, 65535, 63, 1, 1'b0);
        send_word(fbcd_pkg::MODE_FILL, 16'h5555);
        send_word(fbcd_pkg::MODE_LOOKUP, 16'hABCD);
    endtask

    task automatic test_output_backpressure();
        apply_settings(16, 4096, 0, 8, 1'b0);
        no_idle = 1'b1;
        rx_hold = RX_LONG_HOLD;
        for (int i = 0; i < 12; i++)
            send_word((i % 3 == 0) ? fbcd_pkg::MODE_LOOKUP : fbcd_pkg::MODE_FILL,
                      fbcd_pkg::ID_W'($urandom_range(0, 4095)));
        no_idle = 1'b0;
    endtask

    task automatic test_random_traffic(int words);
        int unsigned nc, bc, own, ce, n_eff, pick;
        logic [fbcd_pkg::ID_W-1:0]   id_pool [8];
        logic [fbcd_pkg::ID_W-1:0]   id;
        logic [fbcd_pkg::MODE_W-1:0] mode;
        int phase, count;
        phase = 0;
        while (words > 0) begin
            case ($urandom_range(0, 5))
                0: nc = 1;
                1: nc = fbcd_pkg::MAX_NODES;
                2: nc = 0;
                3: nc = $urandom_range(fbcd_pkg::MAX_NODES + 1, 127);
                default: nc = $urandom_range(2, 16);
            endcase
            case ($urandom_range(0, 4))
                0: bc = 1;
                1: bc = 65535;
                2: bc = $urandom_range(1, 200);
                3: bc = $urandom_range(1, 40);
                default: bc = $urandom_range(1, 65535);
            endcase
            n_eff = (nc == 0) ? 1 :
                    ((nc > fbcd_pkg::MAX_NODES) ? fbcd_pkg::MAX_NODES : nc);
            own = $urandom_range(0, 1) ? $urandom_range(0, 63)
                                       : $urandom_range(0, n_eff - 1);
            case ($urandom_range(0, 5))
                0: ce = 0;
                1: ce = fbcd_pkg::DEF_CACHE_DEPTH;
                2: ce = 31;
                3: ce = 1;
                default: ce = $urandom_range(2, 15);
            endcase
            apply_settings(nc, bc, own, ce, $urandom_range(0, 1));
            foreach (id_pool[i])
                id_pool[i] = fbcd_pkg::ID_W'($urandom_range(0, 65535) % bc);
            no_idle = (phase % 4 == 2);
            count = $urandom_range(60, 140);
            for (int i = 0; i < count && words > 0; i++) begin
                pick = $urandom_range(0, 99);
                if (pick < 35)      mode = fbcd_pkg::MODE_LOOKUP;
                else if (pick < 65) mode = fbcd_pkg::MODE_FILL;
                else if (pick < 93) mode = fbcd_pkg::MODE_INVAL;
                else                mode = fbcd_pkg::MODE_NONE;
                pick = $urandom_range(0, 99);
                if (pick < 60)      id = id_pool[$urandom_range(0, 7)];
                else if (pick < 85) id = fbcd_pkg::ID_W'($urandom_range(0, 65535) % bc);
                else                id = fbcd_pkg::ID_W'($urandom_range(0, 65535));
                send_word(mode, id);
                words--;
            end
            no_idle = 1'b0;
            phase++;
        end
    endtask

    initial begin
        cfg_nodes   = 1;
        cfg_blocks  = 1;
        cfg_own     = 0;
        cfg_entries = 1;
        fill_ptr    = 0;
        foreach (tag_store[i]) begin
            tag_store[i] = '1;
            tag_valid[i] = 1'b0;
        end
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_state();
        test_home_node();
        test_fifo_replacement();
        test_output_backpressure();
        test_random_traffic(900);
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("checked %0d of %0d directory words over %0d register settings,",
                 words_checked, words_sent, settings_count);
        $display("with random gaps on both sides and one long output stall");
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
src/fbcd_pkg.sv
src/fbcd_div.sv
src/fbcd_datapath.sv
src/fbcd_ctrl.sv
src/fifo_block_cache_directory.sv
tb/sv/tb.sv
